// ===== rtl/rtlle_pkg.sv =====
package rtlle_pkg;

    localparam int NODES     = 1024;
    localparam int FEATURES  = 256;
    localparam int MAX_TERMS = 16;
    localparam int MAX_DEPTH = 32;

    localparam int NODE_AW  = $clog2(NODES);
    localparam int TERM_AW  = $clog2(MAX_TERMS);
    localparam int FEAT_AW  = $clog2(FEATURES);
    localparam int COEF_AW  = NODE_AW + TERM_AW;
    localparam int DEPTH_W  = $clog2(MAX_DEPTH + 1);

    // node word: split, threshold, left, right, label, term count
    localparam int NODE_W = 9 + 32 + 11 + 11 + 16 + 5;
    localparam int TERM_W = 32 + 9;

    localparam logic [1:0] OP_WR_NODE = 2'd0;
    localparam logic [1:0] OP_WR_TERM = 2'd1;
    localparam logic [1:0] OP_WR_FEAT = 2'd2;
    localparam logic [1:0] OP_EVAL    = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_CHILD = 3'd1;
    localparam logic [2:0] ST_TOO_DEEP  = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_BAD_TERM  = 3'd4;

    localparam logic [0:0] REG_NUM_FEATURES = 1'd0;
    localparam logic [0:0] REG_NUM_NODES    = 1'd1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [9:0]         node_index;
        logic [8:0]         split_feature;
        logic [10:0]        left_child;
        logic [10:0]        right_child;
        logic [15:0]        node_label;
        logic [4:0]         term_count;
        logic [3:0]         term_index;
        logic [8:0]         term_feature;
        logic [7:0]         feature_slot;
        logic signed [31:0] number_value;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] prediction;
        logic [15:0]        leaf_label;
        logic [2:0]         status;
    } t_out_word;

    typedef struct packed {
        logic [8:0]         split;
        logic signed [31:0] thresh;
        logic [10:0]        left;
        logic [10:0]        right;
        logic [15:0]        label;
        logic [4:0]         tcount;
    } t_node;

    typedef struct packed {
        logic signed [31:0] coef;
        logic [8:0]         feat;
    } t_term;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NODE_RD,
        S_NODE_CHK,
        S_FEAT_WAIT,
        S_DECIDE,
        S_TERM_RD,
        S_TERM_CHK,
        S_MUL,
        S_ACC,
        S_DONE
    } t_state;

endpackage

// ===== rtl/rtlle_ram.sv =====
module rtlle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/regression_tree_linear_leaf_eval.sv =====
// Write operations complete on accept and never raise busy.
// Evaluate: each tree level walked passes node read, node check, feature wait and decide;
// the final node passes node read and check; each leaf term passes term read, term check,
// multiply and accumulate; then the result is strobed, and busy drops in the cycle after it.
// One item at a time; the result strobe lasts one cycle and cannot be stalled.
// Synchronous active-low reset returns the state to idle and sets the config registers (256 / 1024);
// the memories keep no reset and read undefined until written.
module regression_tree_linear_leaf_eval (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  rtlle_pkg::t_in_word       i_word,
    output logic                      o_valid,
    output rtlle_pkg::t_out_word      o_word,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import rtlle_pkg::*;

    logic [8:0]  r_num_features;
    logic [10:0] r_num_nodes;
    logic [0:0]  cfg_idx;
    logic [8:0]  nf;
    logic [10:0] nn;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[2:2];
    assign prdata  = (paddr[1:0] != 2'd0) ? 32'd0 :
                     (cfg_idx == REG_NUM_FEATURES) ? {23'd0, r_num_features}
                                                   : {21'd0, r_num_nodes};
    assign nf = (r_num_features > 9'(FEATURES)) ? 9'(FEATURES) : r_num_features;
    assign nn = (r_num_nodes > 11'(NODES)) ? 11'(NODES) : r_num_nodes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_features <= 9'd256;
            r_num_nodes    <= 11'd1024;
        end else if (psel && penable && pwrite) begin
            case (cfg_idx)
                REG_NUM_FEATURES: r_num_features <= pwdata[8:0];
                REG_NUM_NODES:    r_num_nodes    <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    t_state r_state, n_state;
    logic [NODE_AW-1:0]  r_cur, n_cur;
    logic [DEPTH_W-1:0]  r_depth, n_depth;
    logic [15:0]         r_label, n_label;
    logic [2:0]          r_status, n_status;
    logic signed [63:0]  r_acc, n_acc;
    logic [4:0]          r_tc, n_tc;
    logic [TERM_AW:0]    r_j, n_j;
    logic signed [31:0]  r_coef, n_coef;
    logic signed [63:0]  r_prod, n_prod;
    t_node               r_node, n_node;

    logic accept;
    assign accept = start && !busy;

    t_node nd_w, nd_r;
    t_term tm_w, tm_r;
    logic [31:0] smp_r;
    logic nd_we, tm_we, smp_we;
    logic [NODE_AW-1:0] nd_ra;
    logic [COEF_AW-1:0] tm_wa, tm_ra;
    logic [FEAT_AW-1:0] smp_ra;

    assign nd_w = '{i_word.split_feature, i_word.number_value, i_word.left_child,
                    i_word.right_child, i_word.node_label, i_word.term_count};
    assign tm_w = '{i_word.number_value, i_word.term_feature};
    assign nd_we  = accept && i_word.operation == OP_WR_NODE;
    assign tm_we  = accept && i_word.operation == OP_WR_TERM;
    assign smp_we = accept && i_word.operation == OP_WR_FEAT;
    assign tm_wa  = {i_word.node_index, i_word.term_index};
    assign nd_ra  = r_cur;
    assign tm_ra  = {r_cur, r_j[TERM_AW-1:0]};

    rtlle_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_node_ram (
        .i_clk, .i_we(nd_we), .i_waddr(i_word.node_index), .i_wdata(nd_w),
        .i_raddr(nd_ra), .o_rdata(nd_r));
    rtlle_ram #(.WIDTH(TERM_W), .DEPTH(NODES*MAX_TERMS)) u_term_ram (
        .i_clk, .i_we(tm_we), .i_waddr(tm_wa), .i_wdata(tm_w),
        .i_raddr(tm_ra), .o_rdata(tm_r));
    rtlle_ram #(.WIDTH(32), .DEPTH(FEATURES)) u_sample_ram (
        .i_clk, .i_we(smp_we), .i_waddr(i_word.feature_slot),
        .i_wdata(i_word.number_value), .i_raddr(smp_ra), .o_rdata(smp_r));

    // feature select for split or term; split address held through the wait cycle
    logic [8:0] fsel;
    logic       fok;
    assign fsel = (r_state == S_NODE_CHK)  ? nd_r.split :
                  (r_state == S_FEAT_WAIT) ? r_node.split : tm_r.feat;
    assign fok  = (fsel != 9'd0) && (fsel <= nf);
    assign smp_ra = FEAT_AW'(fsel - 9'd1);
    logic r_fok, n_fok;

    logic [10:0] child;
    assign child = ($signed(smp_r) >= r_node.thresh || !r_fok) &&
                   (r_fok || r_node.thresh <= 0) ? r_node.right : r_node.left;

    logic signed [63:0] shifted;
    assign shifted = r_prod >>> 16;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (accept && i_word.operation == OP_EVAL)
                             n_state = (nn == 11'd0) ? S_DONE : S_NODE_RD;
            S_NODE_RD:   n_state = S_NODE_CHK;
            S_NODE_CHK: begin
                if (nd_r.split == 9'd0)
                    n_state = (nd_r.tcount == 5'd0) ? S_DONE : S_TERM_RD;
                else if (r_depth >= DEPTH_W'(MAX_DEPTH))
                    n_state = S_DONE;
                else
                    n_state = S_FEAT_WAIT;
            end
            S_FEAT_WAIT: n_state = S_DECIDE;
            S_DECIDE:    n_state = (child == 11'd0 || child > nn) ? S_DONE : S_NODE_RD;
            S_TERM_RD:   n_state = S_TERM_CHK;
            S_TERM_CHK:  n_state = S_MUL;
            S_MUL:       n_state = S_ACC;
            S_ACC:       n_state = (5'(r_j) + 5'd1 >= r_tc) ? S_DONE : S_TERM_RD;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cur = r_cur; n_depth = r_depth; n_label = r_label; n_status = r_status;
        n_acc = r_acc; n_tc = r_tc; n_j = r_j; n_coef = r_coef; n_prod = r_prod;
        n_node = r_node; n_fok = r_fok;
        case (r_state)
            S_IDLE: begin
                n_cur = '0; n_depth = '0; n_label = '0; n_acc = '0; n_j = '0;
                n_status = (nn == 11'd0) ? ST_BAD_CHILD : ST_OK;
            end
            S_NODE_CHK: begin
                n_node  = nd_r;
                n_label = nd_r.label;
                n_fok   = fok;
                n_tc    = (nd_r.tcount > 5'(MAX_TERMS)) ? 5'(MAX_TERMS) : nd_r.tcount;
                if (nd_r.split == 9'd0) begin
                    if (nd_r.tcount == 5'd0) n_status = ST_EMPTY;
                end else if (r_depth >= DEPTH_W'(MAX_DEPTH)) begin
                    n_status = ST_TOO_DEEP;
                end else begin
                    n_depth = r_depth + 1'b1;
                end
            end
            S_DECIDE: begin
                if (child == 11'd0 || child > nn) n_status = ST_BAD_CHILD;
                else n_cur = NODE_AW'(child - 11'd1);
            end
            S_TERM_CHK: begin
                n_coef = tm_r.coef;
                n_fok  = fok;
                if (r_j != '0 && !fok) n_status = ST_BAD_TERM;
            end
            S_MUL: begin
                if (r_j == '0) n_prod = 64'(r_coef) <<< 16;
                else if (r_fok) n_prod = 64'(r_coef) * 64'($signed(smp_r));
                else n_prod = '0;
            end
            S_ACC: begin
                n_acc = r_acc + shifted;
                n_j   = r_j + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cur <= n_cur; r_depth <= n_depth; r_label <= n_label; r_status <= n_status;
        r_acc <= n_acc; r_tc <= n_tc; r_j <= n_j; r_coef <= n_coef; r_prod <= n_prod;
        r_node <= n_node; r_fok <= n_fok;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);
    always_comb begin
        o_word.leaf_label = r_label;
        o_word.status     = r_status;
        if (r_status != ST_OK && r_status != ST_BAD_TERM)
            o_word.prediction = '0;
        else if (r_acc > 64'sd2147483647)
            o_word.prediction = 32'sh7fffffff;
        else if (r_acc < -64'sd2147483648)
            o_word.prediction = 32'sh80000000;
        else
            o_word.prediction = r_acc[31:0];
    end
endmodule
